// ===== sv/dmc_pkg.sv =====
// Shared types and codes for the direct-mapped write-back block cache.
// Used by the front end, the command queue, the back end and the top level.
package dmc_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WDONE = 3'd1;
    localparam logic [2:0] KIND_WBACK = 3'd2;
    localparam logic [2:0] KIND_FETCH = 3'd3;
    localparam logic [2:0] KIND_RANGE = 3'd4;
    localparam logic [2:0] KIND_PROTO = 3'd5;
    localparam logic [2:0] KIND_FLUSH = 3'd6;

    // widest line index the cache supports (up to 64 lines)
    localparam int IDX_MAX_W = 6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] blk_id;
        logic [63:0] write_data;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] result_block;
        logic [63:0] result_data;
        logic        last;
    } rsp_t;

    // classified request handed from front end to back end
    typedef struct packed {
        logic [1:0]           op;
        logic [15:0]          id;
        logic [63:0]          data;
        logic [IDX_MAX_W-1:0] idx;
        logic                 range_err;
    } cmd_t;

endpackage

// ===== sv/direct_mapped_writeback_block_cache.sv =====
// Direct-mapped write-back block cache, top level.
// Path: request beat -> front-end register -> queue -> tag/data read -> result register;
//   a dirty victim adds one writeback beat ahead of the result beat.
// The back end takes one request at a time (read then decide); a flush holds the
//   back end for the whole walk, a read and a check per line plus pop, lookup and done.
// Reset: asynchronous, clears valid/dirty bits and the pending fill, block_count to 65536.
module direct_mapped_writeback_block_cache #(
    parameter int LINES      = 16,
    parameter int BLOCK_BITS = 64,
    parameter int ID_BITS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    // block_count register write
    input  logic          cfg_wen,
    input  logic [16:0]   cfg_wdata,
    // request channel
    input  logic          req_valid,
    output logic          req_ready,
    input  dmc_pkg::req_t req,
    // result channel
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dmc_pkg::rsp_t rsp
);
    import dmc_pkg::*;

    // Front end registers each request beat, checks the id against block_count
    // and derives the line index (id mod LINES) with a reciprocal multiply.
    // The queue decouples it from the back end so requests keep flowing while
    // the back end waits on the result channel.
    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic queue_empty;
    logic pop;
    cmd_t head;

    dmc_front #(
        .LINES   (LINES),
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    dmc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Back end owns all line state. It handles protocol errors against the
    // pending fill, hits and misses, victim writebacks and the flush walk,
    // one result beat at a time through its output register.
    dmc_back #(
        .LINES      (LINES),
        .BLOCK_BITS (BLOCK_BITS),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== sv/dmc_front.sv =====
// Front end: accepts request beats, range-checks the block id and computes the line index.
// Depends on dmc_pkg.
module dmc_front #(
    parameter int LINES   = 16,
    parameter int ID_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wen,
    input  logic [16:0]   cfg_wdata,
    input  logic          req_valid,
    output logic          req_ready,
    input  dmc_pkg::req_t req,
    output logic          push,
    output dmc_pkg::cmd_t push_cmd,
    input  logic          queue_full
);
    import dmc_pkg::*;

    localparam int IdW    = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int Shift  = IdW + IDX_MAX_W;
    localparam int RecipW = Shift + 1;
    localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << Shift) / LINES);
    localparam int RemW   = IdW + IDX_MAX_W + 1;

    logic [16:0]          block_count_reg;
    logic                 a_valid_reg;
    logic [1:0]           a_op_reg;
    logic [IdW-1:0]       a_id_reg;
    logic [63:0]          a_data_reg;
    logic [IdW-1:0]       a_q_reg;
    logic                 a_range_reg;

    logic                 accept;
    logic [IdW-1:0]       in_id;
    logic [IdW+RecipW-1:0] prod;
    logic [RemW-1:0]      ql;
    logic [RemW-1:0]      rem_raw;
    logic [RemW-1:0]      rem;

    assign req_ready = !a_valid_reg || !queue_full;
    assign accept    = req_valid && req_ready;
    assign push      = a_valid_reg && !queue_full;

    // quotient by reciprocal; may come out one low, fixed by a single subtract
    assign in_id = req.blk_id[IdW-1:0];
    assign prod  = (IdW+RecipW)'(in_id) * (IdW+RecipW)'(Recip);

    assign ql      = RemW'(a_q_reg) * RemW'(LINES);
    assign rem_raw = RemW'(a_id_reg) - ql;
    assign rem     = (rem_raw >= RemW'(LINES)) ? rem_raw - RemW'(LINES) : rem_raw;

    always_comb
    begin
        push_cmd.op        = a_op_reg;
        push_cmd.id        = 16'(a_id_reg);
        push_cmd.data      = a_data_reg;
        push_cmd.idx       = IDX_MAX_W'(rem);
        push_cmd.range_err = a_range_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= 17'd65536;
            a_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                block_count_reg <= cfg_wdata;
            end
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_op_reg    <= req.operation;
            a_id_reg    <= in_id;
            a_data_reg  <= req.write_data;
            a_q_reg     <= prod[Shift +: IdW];
            a_range_reg <= (17'(in_id) >= block_count_reg);
        end
    end

endmodule

// ===== sv/dmc_fifo.sv =====
// Two-entry command queue between front end and back end.
// Depends on dmc_pkg for the command type.
module dmc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output dmc_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import dmc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/dmc_back.sv =====
// Back end: line lookup, state update, flush walk and result beats.
// Depends on dmc_pkg; holds the tag/data store and the valid/dirty flops.
module dmc_back #(
    parameter int LINES      = 16,
    parameter int BLOCK_BITS = 64,
    parameter int ID_BITS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dmc_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dmc_pkg::rsp_t rsp
);
    import dmc_pkg::*;

    localparam int IdW  = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int IdxW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int MemW = IdW + BLOCK_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_SEC   = 3'd2;
    localparam logic [2:0] ST_FRD   = 3'd3;
    localparam logic [2:0] ST_FCHK  = 3'd4;
    localparam logic [2:0] ST_FDONE = 3'd5;

    logic [MemW-1:0] mem [LINES];
    logic [MemW-1:0] rd_reg;

    logic [2:0]       state_reg, state_next;
    cmd_t             cmd_reg;
    logic [LINES-1:0] valid_reg, valid_next;
    logic [LINES-1:0] dirty_reg, dirty_next;
    logic             fill_pending_reg, fill_pending_next;
    logic [IdW-1:0]   pend_id_reg, pend_id_next;
    logic [IdxW-1:0]  pend_idx_reg, pend_idx_next;
    logic [IdxW-1:0]  ptr_reg, ptr_next;
    rsp_t             sec_reg, sec_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             slot_free;
    logic             emit;
    rsp_t             emit_val;
    logic             re;
    logic [IdxW-1:0]  raddr;
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [MemW-1:0]  wdata;
    logic [IdW-1:0]   rd_tag;
    logic [BLOCK_BITS-1:0] rd_data;
    logic [IdxW-1:0]  idx;
    logic [IdW-1:0]   cid;
    logic [BLOCK_BITS-1:0] cdata;
    logic             hit;
    logic             victim;
    logic             line_dirty;
    rsp_t             second;

    assign rd_tag  = rd_reg[MemW-1 -: IdW];
    assign rd_data = rd_reg[BLOCK_BITS-1:0];
    assign idx     = cmd_reg.idx[IdxW-1:0];
    assign cid     = cmd_reg.id[IdW-1:0];
    assign cdata   = cmd_reg.data[BLOCK_BITS-1:0];
    assign hit     = valid_reg[idx] && (rd_tag == cid);
    assign victim  = !hit && valid_reg[idx] && dirty_reg[idx];
    assign line_dirty = valid_reg[ptr_reg] && dirty_reg[ptr_reg];

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        second.kind         = KIND_FETCH;
        second.result_block = 16'(cid);
        second.result_data  = 64'd0;
        second.last         = 1'b1;
        if (cmd_reg.op == OP_WRITE)
        begin
            second.kind = KIND_WDONE;
        end
        else if (hit)
        begin
            second.kind        = KIND_READ;
            second.result_data = 64'(rd_data);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        dirty_next        = dirty_reg;
        fill_pending_next = fill_pending_reg;
        pend_id_next      = pend_id_reg;
        pend_idx_next     = pend_idx_reg;
        ptr_next          = ptr_reg;
        sec_next          = sec_reg;
        pop      = 1'b0;
        re       = 1'b0;
        raddr    = ptr_reg;
        we       = 1'b0;
        waddr    = idx;
        wdata    = {cid, cdata};
        emit     = 1'b0;
        emit_val.kind         = KIND_PROTO;
        emit_val.result_block = 16'd0;
        emit_val.result_data  = 64'd0;
        emit_val.last         = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    re         = 1'b1;
                    raddr      = head.idx[IdxW-1:0];
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                    if (cmd_reg.op == OP_FILL)
                    begin
                        emit = 1'b1;
                        if (fill_pending_reg)
                        begin
                            we    = 1'b1;
                            waddr = pend_idx_reg;
                            wdata = {pend_id_reg, cdata};
                            valid_next[pend_idx_reg] = 1'b1;
                            dirty_next[pend_idx_reg] = 1'b0;
                            fill_pending_next = 1'b0;
                            emit_val.kind         = KIND_READ;
                            emit_val.result_block = 16'(pend_id_reg);
                            emit_val.result_data  = 64'(cdata);
                        end
                    end
                    else if (fill_pending_reg)
                    begin
                        emit = 1'b1;
                    end
                    else if (cmd_reg.op == OP_FLUSH)
                    begin
                        ptr_next   = '0;
                        state_next = ST_FRD;
                    end
                    else if (cmd_reg.range_err)
                    begin
                        emit = 1'b1;
                        emit_val.kind         = KIND_RANGE;
                        emit_val.result_block = 16'(cid);
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (cmd_reg.op == OP_WRITE)
                        begin
                            we = 1'b1;
                            valid_next[idx] = 1'b1;
                            dirty_next[idx] = 1'b1;
                        end
                        else if (!hit)
                        begin
                            fill_pending_next = 1'b1;
                            pend_id_next      = cid;
                            pend_idx_next     = idx;
                        end
                        if (victim)
                        begin
                            emit_val.kind         = KIND_WBACK;
                            emit_val.result_block = 16'(rd_tag);
                            emit_val.result_data  = 64'(rd_data);
                            emit_val.last         = 1'b0;
                            sec_next   = second;
                            state_next = ST_SEC;
                        end
                        else
                        begin
                            emit_val = second;
                        end
                    end
                end
            end
            ST_SEC:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_val   = sec_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_FRD:
            begin
                re         = 1'b1;
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                if (!line_dirty || slot_free)
                begin
                    if (line_dirty)
                    begin
                        emit = 1'b1;
                        emit_val.kind         = KIND_WBACK;
                        emit_val.result_block = 16'(rd_tag);
                        emit_val.result_data  = 64'(rd_data);
                        emit_val.last         = 1'b0;
                    end
                    if (ptr_reg == IdxW'(LINES - 1))
                    begin
                        state_next = ST_FDONE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_FRD;
                    end
                end
            end
            ST_FDONE:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    emit_val.kind = KIND_FLUSH;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            dirty_reg        <= '0;
            fill_pending_reg <= 1'b0;
            pend_id_reg      <= '0;
            pend_idx_reg     <= '0;
            ptr_reg          <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            dirty_reg        <= dirty_next;
            fill_pending_reg <= fill_pending_next;
            pend_id_reg      <= pend_id_next;
            pend_idx_reg     <= pend_idx_next;
            ptr_reg          <= ptr_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        sec_reg <= sec_next;
        if (emit)
        begin
            rsp_reg <= emit_val;
        end
    end

    // tag/data store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

`ifndef SYNTHESIS
    a_sec_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEC) |-> sec_reg.last)
        else $error("second result of a request not marked last");

    a_fetch_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_val.kind == KIND_FETCH) |=> fill_pending_reg)
        else $error("fetch issued without a pending fill");

    a_flush_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.kind == KIND_FLUSH) |-> rsp_reg.last)
        else $error("flush done beat not marked last");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the direct-mapped write-back block cache.
// Needs dmc_pkg (request/result structs, op and kind codes) and the cache top level.
// Checks every result beat against a cycle-free model of the cache state.
`timescale 1ns / 100ps

module tb_top;
    import dmc_pkg::*;

    localparam int CACHE_LINES  = 16;
    localparam int DRAIN_CYCLES = 12;    // margin past the first-beat latency
    localparam int LONG_STALL   = 300;   // receiver hold-off, long enough to back up the input
    localparam int POOL_SIZE    = 20;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;

    always #2 clk = ~clk;

    direct_mapped_writeback_block_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // Cache shadow state: what the lines must hold after each request beat
    // ------------------------------------------------------------------
    logic        line_valid [CACHE_LINES];
    logic        line_dirty [CACHE_LINES];
    logic [15:0] line_tag   [CACHE_LINES];
    logic [63:0] line_data  [CACHE_LINES];
    logic        fill_pending;
    logic [15:0] pending_block;
    logic [16:0] cache_block_count;

    rsp_t expected_rsp [$];     // result beats still owed by the DUT, oldest first
    req_t pending_reqs [$];     // request beats not yet offered

    // bench controls, written by the sequencer with NBAs
    int   send_idle_pct = 21;
    int   recv_idle_pct = 77;
    logic send_hold     = 1'b0;
    logic stall_tog     = 1'b0;

    // receiver-private
    logic stall_seen = 1'b0;
    int   stall_left = 0;

    // stats
    int   errors        = 0;
    int   req_beats     = 0;
    int   rsp_beats     = 0;
    int   deepest_flush = 0;

    logic [15:0] id_pool [POOL_SIZE];

    function automatic rsp_t make_beat(logic [2:0] k, logic [15:0] blk, logic [63:0] d);
        rsp_t b;
        b.kind         = k;
        b.result_block = blk;
        b.result_data  = d;
        b.last         = 1'b0;
        return b;
    endfunction

    // Apply one request beat to the shadow cache and queue the result beats it owes.
    function automatic void predict_cache(req_t r);
        rsp_t beats [$];
        rsp_t item;
        int   line;
        int   wbacks;
        logic hit;
        line   = r.blk_id % CACHE_LINES;
        wbacks = 0;
        if (r.operation == OP_FILL)
        begin
            if (!fill_pending)
                beats.push_back(make_beat(KIND_PROTO, '0, '0));
            else
            begin
                // fill lands on the pending block's line, no range check, installs clean
                line             = pending_block % CACHE_LINES;
                line_data[line]  = r.write_data;
                line_tag[line]   = pending_block;
                line_valid[line] = 1'b1;
                line_dirty[line] = 1'b0;
                fill_pending     = 1'b0;
                beats.push_back(make_beat(KIND_READ, pending_block, r.write_data));
            end
        end
        else if (fill_pending)
            beats.push_back(make_beat(KIND_PROTO, '0, '0));
        else if (r.operation == OP_FLUSH)
        begin
            // dirty bits are left set, so a second flush repeats the writebacks
            for (int i = 0; i < CACHE_LINES; i++)
                if (line_valid[i] && line_dirty[i])
                begin
                    beats.push_back(make_beat(KIND_WBACK, line_tag[i], line_data[i]));
                    wbacks++;
                end
            beats.push_back(make_beat(KIND_FLUSH, '0, '0));
            if (wbacks > deepest_flush)
                deepest_flush = wbacks;
        end
        else if ({1'b0, r.blk_id} >= cache_block_count)
            beats.push_back(make_beat(KIND_RANGE, r.blk_id, '0));
        else
        begin
            hit = line_valid[line] && (line_tag[line] == r.blk_id);
            if (!hit && line_valid[line] && line_dirty[line])
                beats.push_back(make_beat(KIND_WBACK, line_tag[line], line_data[line]));
            if (r.operation == OP_WRITE)
            begin
                line_data[line]  = r.write_data;
                line_tag[line]   = r.blk_id;
                line_valid[line] = 1'b1;
                line_dirty[line] = 1'b1;
                beats.push_back(make_beat(KIND_WDONE, r.blk_id, '0));
            end
            else if (hit)
                beats.push_back(make_beat(KIND_READ, r.blk_id, line_data[line]));
            else
            begin
                fill_pending  = 1'b1;
                pending_block = r.blk_id;
                beats.push_back(make_beat(KIND_FETCH, r.blk_id, '0));
            end
        end
        for (int i = 0; i < beats.size(); i++)
        begin
            item      = beats[i];
            item.last = (i == beats.size() - 1);
            expected_rsp.push_back(item);
        end
    endfunction

    function automatic void check_beat(rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            $display("%0t: result beat with nothing expected: kind %0d block %h data %h last %0d",
                     $time, got.kind, got.result_block, got.result_data, got.last);
            errors++;
            return;
        end
        want = expected_rsp.pop_front();
        if (got.kind !== want.kind || got.result_block !== want.result_block ||
            got.result_data !== want.result_data || got.last !== want.last)
        begin
            $display("%0t: result mismatch, expected kind %0d block %h data %h last %0d",
                     $time, want.kind, want.result_block, want.result_data, want.last);
            $display("%0t:                  actual kind %0d block %h data %h last %0d",
                     $time, got.kind, got.result_block, got.result_data, got.last);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: holds a beat until it is taken, idles at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && req_ready)
            begin
                predict_cache(req);
                req_beats++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() > 0 && !send_hold &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks accepted beats, drives rsp_ready.
    // A toggle of stall_tog starts a long hold-off counted here.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_beat(rsp);
                rsp_beats++;
            end
            if (stall_tog != stall_seen)
            begin
                stall_seen = stall_tog;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(logic [1:0] op, logic [15:0] id, logic [63:0] d);
        req_t r;
        r.operation  = op;
        r.blk_id     = id;
        r.write_data = d;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] rand_id();
        return 16'($urandom_range(65535, 0));
    endfunction

    // mostly ids from a small pool so lines hit and alias; the rest anywhere
    function automatic logic [15:0] pick_block_id();
        if ($urandom_range(99, 0) < 70)
            return id_pool[$urandom_range(POOL_SIZE - 1, 0)];
        return rand_id();
    endfunction

    // Mostly well-formed traffic: a read is usually chased by its fill.
    task automatic queue_random_items(int count);
        int n;
        int pick;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 38)
            begin
                push_req(OP_READ, pick_block_id(), rand_word());
                n++;
                if ($urandom_range(99, 0) < 85)
                begin
                    push_req(OP_FILL, rand_id(), rand_word());
                    n++;
                end
            end
            else if (pick < 80)
                push_req(OP_WRITE, pick_block_id(), rand_word());
            else if (pick < 88)
                push_req(OP_FLUSH, rand_id(), rand_word());
            else if (pick < 94)
                push_req(OP_FILL, rand_id(), rand_word());   // stray fill
            else
                push_req(2'($urandom_range(3, 0)), rand_id(), rand_word());
            if (pick >= 38)
                n++;
        end
    endtask

    // Every request owes at least one result, so an empty score means idle.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_block_count(logic [16:0] value);
        wait_drained();
        @(posedge clk);
        cfg_wen           <= 1'b1;
        cfg_wdata         <= value;
        cache_block_count  = value;
        @(posedge clk);
        cfg_wen           <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < CACHE_LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_tag[i]   = '0;
            line_data[i]  = '0;
        end
        fill_pending      = 1'b0;
        pending_block     = '0;
        cache_block_count = 17'd65536;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = rand_id();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset block_count: hits, dirty victims, requests while a
        // fill is pending, fill with none pending, repeated flush.
        push_req(OP_WRITE, 16'h0000, '1);
        push_req(OP_WRITE, 16'hFFFF, '0);
        push_req(OP_READ,  16'h0000, '0);                     // hit
        push_req(OP_READ,  16'h0010, '1);                     // dirty victim, fetch
        push_req(OP_READ,  16'h0020, '0);                     // blocked by pending fill
        push_req(OP_WRITE, 16'h0020, 64'h5555_5555_5555_5555);
        push_req(OP_FLUSH, 16'h0000, '0);
        push_req(OP_FILL,  16'hFFFF, 64'h0123_4567_89AB_CDEF); // id ignored
        push_req(OP_FILL,  16'h0000, '1);                     // nothing pending
        push_req(OP_READ,  16'h0010, '0);                     // clean hit
        push_req(OP_WRITE, 16'h0010, 64'hAAAA_AAAA_AAAA_AAAA);
        push_req(OP_WRITE, 16'h0020, 64'hFEDC_BA98_7654_3210);// dirty victim on write miss
        push_req(OP_READ,  16'hFFEF, '0);
        push_req(OP_FILL,  16'h1234, 64'h8000_0000_0000_0001);
        push_req(OP_FLUSH, 16'hFFFF, '1);
        push_req(OP_FLUSH, 16'h0000, '0);                     // dirty bits still set

        // narrow the id range: out-of-range reads and writes
        write_block_count(17'd256);
        push_req(OP_WRITE, 16'h0100, '1);
        push_req(OP_READ,  16'hFFFF, '0);
        push_req(OP_WRITE, 16'h00FF, 64'h0F0F_0F0F_0F0F_0F0F);// clean victim, no writeback
        push_req(OP_READ,  16'h0043, '0);                     // leaves a fill pending

        // zero ids valid; the pending fill still lands
        write_block_count(17'd0);
        push_req(OP_FILL,  16'h0000, 64'hC3C3_C3C3_C3C3_C3C3);
        push_req(OP_WRITE, 16'h0005, '1);
        push_req(OP_READ,  16'h0000, '0);
        push_req(OP_FLUSH, 16'h0000, '0);

        // random, every id valid, slow receiver
        write_block_count(17'h1FFFF);
        queue_random_items(100);

        // random, partial id range, slow sender
        write_block_count(17'd40000);
        send_idle_pct <= 77;
        recv_idle_pct <= 21;
        queue_random_items(100);

        // random, back to full range, no idling; long receiver hold-off
        // backs the block up, then the sender pauses until all results are in
        write_block_count(17'd65536);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random_items(86);
        stall_tog <= ~stall_tog;
        while (pending_reqs.size() > 40)
            @(posedge clk);
        send_hold <= 1'b1;
        @(posedge clk);
        while (req_valid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        send_hold <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);     // catch stray beats after the last one owed

        $display("Ran %0d request beats and checked %0d result beats", req_beats, rsp_beats);
        $display("block_count 65536/256/0/131071/40000, widest flush %0d writebacks",
                 deepest_flush);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("Timeout with %0d result beats still owed", expected_rsp.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
